// ===== rtl/vn3_pkg.sv =====
// ----------------------------------------------------------------------------
// vn3_pkg
// Shared widths, function codes and control types of the 3D value noise
// sampler.
// ----------------------------------------------------------------------------
package vn3_pkg;

  // Fixed field widths of the input and result channels
  localparam int COORD_W = 24;
  localparam int INDEX_W = 12;
  localparam int ENTRY_W = 16;
  localparam int NOISE_W = 16;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } vn3_func_t;

  // Load enables of the four coordinate split stages
  typedef struct packed {
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } vn3_split_en_t;

endpackage

// ===== rtl/vn3_if.sv =====
// ----------------------------------------------------------------------------
// vn3 channel interfaces
// Valid/ready channels for input items and noise results.
// ----------------------------------------------------------------------------
interface vn3_in_if import vn3_pkg::*; ();
  logic                       valid;
  logic                       ready;
  vn3_func_t                  func;
  logic [INDEX_W-1:0]         entry_index;
  logic [ENTRY_W-1:0]         entry_value;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;

  modport source (
    output valid, func, entry_index, entry_value, coord_x, coord_y, coord_z,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_value, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

interface vn3_out_if import vn3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;

  modport source (
    output valid, noise_value,
    input  ready
  );
  modport sink (
    input  valid, noise_value,
    output ready
  );
endinterface

// ===== rtl/vn3_lattice_bank.sv =====
// ----------------------------------------------------------------------------
// vn3_lattice_bank
// One copy of the lattice: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module vn3_lattice_bank #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr0,
  input  logic [ADDR_W-1:0] rd_addr1,
  output logic [DATA_W-1:0] rd_data0,
  output logic [DATA_W-1:0] rd_data1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== rtl/vn3_coord_split.sv =====
// ----------------------------------------------------------------------------
// vn3_coord_split
// Four-stage floor and periodic wrap of one fixed-point coordinate.
// ----------------------------------------------------------------------------
module vn3_coord_split import vn3_pkg::*; #(
  parameter  int LATTICE_SIZE = 16,
  parameter  int FRAC_BITS    = 8,
  localparam int CW           = $clog2(LATTICE_SIZE)
) (
  input  logic                      clk,
  input  vn3_split_en_t             en,
  input  logic signed [COORD_W-1:0] coord,
  output logic [CW-1:0]             cell0,
  output logic [CW-1:0]             cell1,
  output logic [FRAC_BITS-1:0]      frac
);

  // Integer part, biased to unsigned by flipping the sign bit
  localparam int IW = COORD_W - FRAC_BITS;
  localparam int PW = 2 * IW;
  localparam logic [IW-1:0] RECIP   = IW'((2 ** IW) / LATTICE_SIZE);
  localparam logic [CW:0]   L_W     = (CW + 1)'(LATTICE_SIZE);
  localparam logic [CW:0]   BIAS_MD = (CW + 1)'((2 ** (COORD_W - 1 - FRAC_BITS)) % LATTICE_SIZE);

  logic [IW-1:0]        v1_r, v2_r;
  logic [IW-1:0]        q2_r;
  logic [FRAC_BITS-1:0] f1_r, f2_r, f3_r;
  logic [CW-1:0]        vmod3_r;
  logic [PW-1:0]        prod;
  logic [IW-1:0]        r_full;
  logic [CW:0]          r_lo;
  logic [CW:0]          vmod_nxt;
  logic [CW:0]          cell_nxt;
  logic [CW:0]          next_nxt;

  // Quotient estimate by reciprocal: exact or one short
  assign prod = PW'(v1_r) * PW'(RECIP);

  always_comb begin
    r_full   = v2_r - IW'(q2_r * LATTICE_SIZE);
    r_lo     = r_full[CW:0];
    vmod_nxt = (r_lo >= L_W) ? r_lo - L_W : r_lo;
  end

  // Remove the bias modulo the lattice size, then step to the upper corner
  always_comb begin
    if ({1'b0, vmod3_r} >= BIAS_MD) begin
      cell_nxt = {1'b0, vmod3_r} - BIAS_MD;
    end else begin
      cell_nxt = {1'b0, vmod3_r} + L_W - BIAS_MD;
    end
    next_nxt = (cell_nxt + 1'b1 >= L_W) ? '0 : cell_nxt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      v1_r <= {~coord[COORD_W-1], coord[COORD_W-2:FRAC_BITS]};
      f1_r <= coord[FRAC_BITS-1:0];
    end
    if (en.s2) begin
      q2_r <= prod[PW-1:IW];
      v2_r <= v1_r;
      f2_r <= f1_r;
    end
    if (en.s3) begin
      vmod3_r <= vmod_nxt[CW-1:0];
      f3_r    <= f2_r;
    end
    if (en.s4) begin
      cell0 <= cell_nxt[CW-1:0];
      cell1 <= next_nxt[CW-1:0];
      frac  <= f3_r;
    end
  end

endmodule

// ===== rtl/value_noise_3d_sampler_top.sv =====
// ----------------------------------------------------------------------------
// value_noise_3d_sampler_top
// 3D value noise: periodic lattice lookup with trilinear interpolation.
// ----------------------------------------------------------------------------
// Throughput: one item (load or query) per cycle while the output is not
// stalled; set by the 12-stage pipeline and by four lattice copies, each with
// two read ports.
// Reset clears only the stage valid bits; the lattice holds no defined value
// until software loads it, and no clearing pass runs.
// ----------------------------------------------------------------------------
module value_noise_3d_sampler_top import vn3_pkg::*; #(
  parameter int LATTICE_SIZE = 16,
  parameter int FRAC_BITS    = 8,
  parameter int VALUE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  vn3_in_if.sink      in_ch,
  vn3_out_if.source   out_ch
);

  // Geometry of the lattice
  localparam int CW    = $clog2(LATTICE_SIZE);
  localparam int DEPTH = LATTICE_SIZE * LATTICE_SIZE * LATTICE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int VB    = VALUE_BITS;
  // Width of a blend product: signed difference times fraction
  localparam int PRW   = VB + FRAC_BITS + 2;
  localparam int NST   = 12;

  // --------------------------------------------------------------------------
  // Stage map
  //   s1..s4  floor and wrap of the three coordinates (vn3_coord_split)
  //   s5      corner addresses and lattice write request
  //   s6      corner values (bank read registers)
  //   s7/s8   blend along z, four lanes (multiply, then add)
  //   s9/s10  blend along y, two lanes
  //   s11/s12 blend along x; s12 is the output register
  // Loads and queries travel the same stages, so a load takes effect in the
  // lattice at s5, in order with the reads of the queries around it.
  // --------------------------------------------------------------------------

  function automatic logic [AW-1:0] lat_addr(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z);
    return AW'(int'(x) + LATTICE_SIZE * int'(y)
               + LATTICE_SIZE * LATTICE_SIZE * int'(z));
  endfunction

  // (hi - lo) * f, kept signed
  function automatic logic signed [PRW-1:0] lerp_mul(input logic [VB-1:0] lo,
                                                     input logic [VB-1:0] hi,
                                                     input logic [FRAC_BITS-1:0] f);
    logic signed [VB:0] diff;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    return PRW'(diff) * $signed(PRW'({1'b0, f}));
  endfunction

  // lo + floor(p / 2^FRAC_BITS): same as the truncated two-product blend
  function automatic logic [VB-1:0] lerp_add(input logic [VB-1:0] lo,
                                             input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] s;
    s = $signed(PRW'(lo)) + (p >>> FRAC_BITS);
    return s[VB-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its content moves on.
  // Bubbles collapse, so the input keeps taking items while a result waits, until every stage is full.
  // --------------------------------------------------------------------------
  logic [NST:1] vld_r;
  logic [NST:1] vld_nxt;
  logic [NST:1] ld;

  vn3_func_t          func_r [1:4];
  vn3_func_t          func5_r;
  logic [INDEX_W-1:0] idx_r  [1:4];
  logic [ENTRY_W-1:0] val_r  [1:4];

  always_comb begin
    ld[NST] = ~vld_r[NST] | out_ch.ready;
    for (int i = NST - 1; i >= 1; i--) begin
      ld[i] = ~vld_r[i] | ld[i + 1];
    end
  end

  always_comb begin
    vld_nxt[1] = in_ch.valid;
    for (int i = 2; i <= NST; i++) begin
      vld_nxt[i] = vld_r[i - 1];
    end
    // Drop load items once their write is done
    vld_nxt[6] = vld_r[5] & (func5_r == FUNC_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= NST; i++) begin
        if (ld[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  assign in_ch.ready = ld[1];

  // --------------------------------------------------------------------------
  // s1..s4: coordinate split, with the load fields riding alongside
  // --------------------------------------------------------------------------
  vn3_split_en_t        split_en;
  logic [CW-1:0]        cx0, cx1, cy0, cy1, cz0, cz1;
  logic [FRAC_BITS-1:0] fx4, fy4, fz4;

  assign split_en = '{s4: ld[4], s3: ld[3], s2: ld[2], s1: ld[1]};

  vn3_coord_split #(.LATTICE_SIZE(LATTICE_SIZE), .FRAC_BITS(FRAC_BITS)) u_split_x (
    .clk(clk), .en(split_en), .coord(in_ch.coord_x),
    .cell0(cx0), .cell1(cx1), .frac(fx4)
  );
  vn3_coord_split #(.LATTICE_SIZE(LATTICE_SIZE), .FRAC_BITS(FRAC_BITS)) u_split_y (
    .clk(clk), .en(split_en), .coord(in_ch.coord_y),
    .cell0(cy0), .cell1(cy1), .frac(fy4)
  );
  vn3_coord_split #(.LATTICE_SIZE(LATTICE_SIZE), .FRAC_BITS(FRAC_BITS)) u_split_z (
    .clk(clk), .en(split_en), .coord(in_ch.coord_z),
    .cell0(cz0), .cell1(cz1), .frac(fz4)
  );

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      func_r[1] <= in_ch.func;
      idx_r[1]  <= in_ch.entry_index;
      val_r[1]  <= in_ch.entry_value;
    end
    for (int i = 2; i <= 4; i++) begin
      if (ld[i]) begin
        func_r[i] <= func_r[i - 1];
        idx_r[i]  <= idx_r[i - 1];
        val_r[i]  <= val_r[i - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // s5: corner addresses per bank, lattice write request
  // Bank k serves the x/y corner {x sel, y sel} = k, at both z corners.
  // --------------------------------------------------------------------------
  logic [AW-1:0]        raddr0_r [4];
  logic [AW-1:0]        raddr1_r [4];
  logic [AW-1:0]        waddr5_r;
  logic [VB-1:0]        wval5_r;
  logic                 wr_ok5_r;
  logic [FRAC_BITS-1:0] fx5_r, fy5_r, fz5_r;
  logic                 wr_en;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int k = 0; k < 4; k++) begin
        raddr0_r[k] <= lat_addr(k[1] ? cx1 : cx0, k[0] ? cy1 : cy0, cz0);
        raddr1_r[k] <= lat_addr(k[1] ? cx1 : cx0, k[0] ? cy1 : cy0, cz1);
      end
      func5_r   <= func_r[4];
      waddr5_r  <= AW'(idx_r[4]);
      wval5_r   <= VB'(val_r[4]);
      // Ignore a load beyond the lattice
      wr_ok5_r  <= (int'(idx_r[4]) < DEPTH);
      fx5_r     <= fx4;
      fy5_r     <= fy4;
      fz5_r     <= fz4;
    end
  end

  // Write as the load item leaves s5
  assign wr_en = vld_r[5] & ld[6] & (func5_r == FUNC_WRITE) & wr_ok5_r;

  // --------------------------------------------------------------------------
  // s6: corner values from four lattice copies
  // --------------------------------------------------------------------------
  logic [VB-1:0]        zlo [4];
  logic [VB-1:0]        zhi [4];
  logic [FRAC_BITS-1:0] fx6_r, fy6_r, fz6_r;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    vn3_lattice_bank #(.DEPTH(DEPTH), .ADDR_W(AW), .DATA_W(VB)) u_bank (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_addr  (waddr5_r),
      .wr_data  (wval5_r),
      .rd_en    (ld[6]),
      .rd_addr0 (raddr0_r[k]),
      .rd_addr1 (raddr1_r[k]),
      .rd_data0 (zlo[k]),
      .rd_data1 (zhi[k])
    );
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      fx6_r <= fx5_r;
      fy6_r <= fy5_r;
      fz6_r <= fz5_r;
    end
  end

  // --------------------------------------------------------------------------
  // s7..s12: blend along z, then y, then x
  // --------------------------------------------------------------------------
  logic signed [PRW-1:0] pz7_r [4];
  logic [VB-1:0]         lz7_r [4];
  logic [VB-1:0]         vz8_r [4];
  logic signed [PRW-1:0] py9_r [2];
  logic [VB-1:0]         ly9_r [2];
  logic [VB-1:0]         vy10_r [2];
  logic signed [PRW-1:0] px11_r;
  logic [VB-1:0]         lx11_r;
  logic [NOISE_W-1:0]    out_r;
  logic [FRAC_BITS-1:0]  fx7_r, fy7_r, fx8_r, fy8_r, fx9_r, fx10_r;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      for (int k = 0; k < 4; k++) begin
        pz7_r[k] <= lerp_mul(zlo[k], zhi[k], fz6_r);
        lz7_r[k] <= zlo[k];
      end
      fx7_r <= fx6_r;
      fy7_r <= fy6_r;
    end
    if (ld[8]) begin
      for (int k = 0; k < 4; k++) begin
        vz8_r[k] <= lerp_add(lz7_r[k], pz7_r[k]);
      end
      fx8_r <= fx7_r;
      fy8_r <= fy7_r;
    end
    if (ld[9]) begin
      // Lane 0 pairs y0/y1 at x0, lane 1 at x1
      for (int j = 0; j < 2; j++) begin
        py9_r[j] <= lerp_mul(vz8_r[2 * j], vz8_r[2 * j + 1], fy8_r);
        ly9_r[j] <= vz8_r[2 * j];
      end
      fx9_r <= fx8_r;
    end
    if (ld[10]) begin
      for (int j = 0; j < 2; j++) begin
        vy10_r[j] <= lerp_add(ly9_r[j], py9_r[j]);
      end
      fx10_r <= fx9_r;
    end
    if (ld[11]) begin
      px11_r <= lerp_mul(vy10_r[0], vy10_r[1], fx10_r);
      lx11_r <= vy10_r[0];
    end
    if (ld[12]) begin
      out_r <= NOISE_W'(lerp_add(lx11_r, px11_r));
    end
  end

  // Hold the result until the transfer out
  assign out_ch.valid       = vld_r[NST];
  assign out_ch.noise_value = out_r;

endmodule
